// ===== sv/diagonal_zigzag_reorder_macros.svh =====
// ----------------------------------------------------------------------------
// diagonal zigzag reorder assertion macros
// shared assertion forms, clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DIAGONAL_ZIGZAG_REORDER_MACROS_SVH
`define DIAGONAL_ZIGZAG_REORDER_MACROS_SVH

// property that must hold at every edge out of reset
`define DZR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define DZR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/dzr_pkg.sv =====
// ----------------------------------------------------------------------------
// dzr_pkg
// types and constants shared by the diagonal zigzag reorder modules
// ----------------------------------------------------------------------------
package dzr_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned DimW       = 4;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned StoreAddrW = $clog2(StoreDepth);
  localparam int unsigned TotalW     = StoreAddrW + 1;
  localparam int unsigned PAddrW     = 3;
  localparam int unsigned PDataW     = 32;
  localparam int unsigned JobQDepth  = 2;
  localparam int unsigned JobQPtrW   = $clog2(JobQDepth);
  localparam int unsigned JobQCntW   = $clog2(JobQDepth + 1);

  localparam logic [DimW-1:0] DimReset = 4'd8;

  typedef enum logic [0:0] {
    RegRowCount = 1'b0,
    RegColCount = 1'b1
  } reg_idx_e;

  // one traversal, dimensions already clamped
  typedef struct packed {
    logic [DimW-1:0] rows;
    logic [DimW-1:0] cols;
  } job_t;

  typedef struct packed {
    logic                  en;
    logic [StoreAddrW-1:0] addr;
  } mem_wr_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] vmax);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = {{(DimW-1){1'b0}}, 1'b1};
    end else if (v > vmax) begin
      r = vmax;
    end
    return r;
  endfunction

endpackage

// ===== sv/dzr_front.sv =====
// ----------------------------------------------------------------------------
// dzr_front
// register port, element loading and end-of-frame detection
// ----------------------------------------------------------------------------
module dzr_front import dzr_pkg::*; #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic [PAddrW-1:0]        paddr_i,
  input  logic [PDataW-1:0]        pwdata_i,
  output logic [PDataW-1:0]        prdata_o,
  output logic                     pready_o,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ValueW-1:0] element_value_i,
  input  logic                     hold_i,
  output mem_wr_t                  wr_o,
  output logic [DATA_WIDTH-1:0]    wr_data_o,
  output logic                     job_push_o,
  output job_t                     job_o
);

  logic [DimW-1:0]       row_count_q, col_count_q;
  logic [StoreAddrW-1:0] load_count_q, load_count_d;
  logic [DimW-1:0]       rows, cols;
  logic [TotalW-1:0]     total, load_next;
  logic                  accept, frame_done, cfg_wr;
  reg_idx_e              reg_idx;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign reg_idx  = reg_idx_e'(paddr_i[PAddrW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= DimReset;
      col_count_q <= DimReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegRowCount: row_count_q <= pwdata_i[DimW-1:0];
        RegColCount: col_count_q <= pwdata_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRowCount: prdata_o = {{(PDataW-DimW){1'b0}}, row_count_q};
      RegColCount: prdata_o = {{(PDataW-DimW){1'b0}}, col_count_q};
      default:     prdata_o = '0;
    endcase
  end

  assign rows  = clamp_dim(row_count_q, DimW'(MAX_DIM));
  assign cols  = clamp_dim(col_count_q, DimW'(MAX_DIM));
  assign total = TotalW'({{DimW{1'b0}}, rows} * {{DimW{1'b0}}, cols});

  assign in_ready_o = !hold_i;
  assign accept     = in_valid_i && in_ready_o;
  assign load_next  = {1'b0, load_count_q} + TotalW'(1);
  // a shrunk frame size can end the frame on the very next item
  assign frame_done = load_next >= total;

  assign wr_o.en   = accept && ({1'b0, load_count_q} < total);
  assign wr_o.addr = load_count_q;

  generate
    if (DATA_WIDTH > ValueW) begin : g_sext
      assign wr_data_o = {{(DATA_WIDTH-ValueW){element_value_i[ValueW-1]}}, element_value_i};
    end else if (DATA_WIDTH == ValueW) begin : g_same
      assign wr_data_o = element_value_i;
    end else begin : g_trunc
      assign wr_data_o = element_value_i[DATA_WIDTH-1:0];
    end
  endgenerate

  assign job_push_o = accept && frame_done;
  assign job_o.rows = rows;
  assign job_o.cols = cols;

  always_comb begin
    load_count_d = load_count_q;
    if (accept) begin
      load_count_d = frame_done ? '0 : load_next[StoreAddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
    end else begin
      load_count_q <= load_count_d;
    end
  end

endmodule

// ===== sv/dzr_job_fifo.sv =====
// ----------------------------------------------------------------------------
// dzr_job_fifo
// short queue of traversal jobs between the loader and the walker
// ----------------------------------------------------------------------------
module dzr_job_fifo import dzr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t                entries_q [JobQDepth];
  logic [JobQPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobQCntW-1:0] count_q;
  logic                do_push, do_pop;

  assign valid_o = count_q != '0;
  assign job_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && (count_q != JobQCntW'(JobQDepth));
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + JobQPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + JobQPtrW'(1);
      end
      priority if (do_push && !do_pop) begin
        count_q <= count_q + JobQCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - JobQCntW'(1);
      end
    end
  end

endmodule

// ===== sv/dzr_back.sv =====
// ----------------------------------------------------------------------------
// dzr_back
// element store, zigzag walker, read stage and output register
// ----------------------------------------------------------------------------
`include "diagonal_zigzag_reorder_macros.svh"

module dzr_back import dzr_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mem_wr_t                  wr_i,
  input  logic [DATA_WIDTH-1:0]    wr_data_i,
  input  logic                     job_valid_i,
  input  job_t                     job_i,
  output logic                     job_pop_o,
  output logic                     busy_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueW-1:0] out_value_o,
  output logic [IdxW-1:0]          out_row_o,
  output logic [IdxW-1:0]          out_col_o,
  output logic                     out_last_o
);

  typedef enum logic [1:0] {
    WkIdle = 2'b01,
    WkWalk = 2'b10
  } walk_state_e;

  walk_state_e state_q, state_d;
  job_t        job_q;
  logic [TotalW-1:0]     total_q;
  logic [IdxW-1:0]       row_q, row_d, col_q, col_d;
  logic                  up_q, up_d;
  logic [StoreAddrW-1:0] k_q, k_d;

  logic [DATA_WIDTH-1:0] mem_q [StoreDepth];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  rd_valid_q, rd_last_q;
  logic [IdxW-1:0]       rd_row_q, rd_col_q;

  logic                  out_valid_q, out_last_q;
  logic [IdxW-1:0]       out_row_q, out_col_q;
  logic [DATA_WIDTH-1:0] out_data_q;

  logic                  walking, issue, rd_adv, is_last, at_last_col, at_last_row;
  logic [TotalW-1:0]     addr_full;
  logic [StoreAddrW-1:0] addr;

  assign walking   = state_q == WkWalk;
  assign busy_o    = walking;
  assign job_pop_o = (state_q == WkIdle) && job_valid_i;

  assign rd_adv = rd_valid_q && (!out_valid_q || out_ready_i);
  assign issue  = walking && (!rd_valid_q || rd_adv);

  assign is_last     = {1'b0, k_q} == total_q - TotalW'(1);
  assign at_last_col = {1'b0, col_q} == job_q.cols - DimW'(1);
  assign at_last_row = {1'b0, row_q} == job_q.rows - DimW'(1);

  assign addr_full = TotalW'({{DimW{1'b0}}, row_q} * {{IdxW{1'b0}}, job_q.cols})
                     + {{(TotalW-IdxW){1'b0}}, col_q};
  assign addr      = addr_full[StoreAddrW-1:0];

  // next position of the walk along the anti-diagonals
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    up_d    = up_q;
    k_d     = k_q;
    unique case (state_q)
      WkIdle: begin
        if (job_valid_i) begin
          state_d = WkWalk;
          row_d   = '0;
          col_d   = '0;
          up_d    = 1'b1;
          k_d     = '0;
        end
      end
      WkWalk: begin
        if (issue) begin
          if (is_last) begin
            state_d = WkIdle;
          end else begin
            k_d = k_q + StoreAddrW'(1);
            if (up_q) begin
              priority if (at_last_col) begin
                row_d = row_q + IdxW'(1);
                up_d  = 1'b0;
              end else if (row_q == '0) begin
                col_d = col_q + IdxW'(1);
                up_d  = 1'b0;
              end else begin
                row_d = row_q - IdxW'(1);
                col_d = col_q + IdxW'(1);
              end
            end else begin
              priority if (at_last_row) begin
                col_d = col_q + IdxW'(1);
                up_d  = 1'b1;
              end else if (col_q == '0) begin
                row_d = row_q + IdxW'(1);
                up_d  = 1'b1;
              end else begin
                row_d = row_q + IdxW'(1);
                col_d = col_q - IdxW'(1);
              end
            end
          end
        end
      end
      default: state_d = WkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WkIdle;
      row_q   <= '0;
      col_q   <= '0;
      up_q    <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      up_q    <= up_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q   <= job_i;
      total_q <= TotalW'({{DimW{1'b0}}, job_i.rows} * {{DimW{1'b0}}, job_i.cols});
    end
  end

  // element store: one write port from the loader, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_data_i;
    end
    if (issue) begin
      rd_data_q <= mem_q[addr];
      rd_row_q  <= row_q;
      rd_col_q  <= col_q;
      rd_last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        rd_valid_q <= 1'b1;
      end else if (rd_adv) begin
        rd_valid_q <= 1'b0;
      end
      if (rd_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_adv) begin
      out_data_q <= rd_data_q;
      out_row_q  <= rd_row_q;
      out_col_q  <= rd_col_q;
      out_last_q <= rd_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;

  generate
    if (DATA_WIDTH > ValueW) begin : g_trunc
      assign out_value_o = out_data_q[ValueW-1:0];
    end else if (DATA_WIDTH == ValueW) begin : g_same
      assign out_value_o = out_data_q;
    end else begin : g_zext
      assign out_value_o = {{(ValueW-DATA_WIDTH){1'b0}}, out_data_q};
    end
  endgenerate

  `DZR_ASSERT(a_walk_in_frame, walking |-> (({1'b0, row_q} < job_q.rows) && ({1'b0, col_q} < job_q.cols)), "walk left the matrix")
  `DZR_ASSERT(a_last_ends_walk, (issue && is_last) |=> (state_q == WkIdle), "walk kept going after last read")
  `DZR_ASSERT(a_read_stage_held, (rd_valid_q && !rd_adv) |=> (rd_valid_q && $stable(rd_row_q) && $stable(rd_col_q)), "stalled read stage lost its item")
  `DZR_ASSERT_NEVER(a_no_load_during_walk, walking && wr_i.en, "store written while the walk reads it")

endmodule

// ===== sv/diagonal_zigzag_reorder.sv =====
// ----------------------------------------------------------------------------
// diagonal_zigzag_reorder
// collects a row-major matrix and replays it in diagonal zigzag order
// ----------------------------------------------------------------------------
// Elements are loaded one per cycle while not held off, in row-major order,
// into a 64-entry store. The item that completes a rows x cols frame queues
// a traversal job; the walker then reads the store once per cycle while the
// output is not stalled, through its single read port, and emits rows*cols
// results with row, column and a last flag. New elements are held off from
// the completing item until the walker has issued its final read. Row and
// column counts are clamped to 1..MAX_DIM when a frame is classified, and a
// size change part-way through a frame takes effect on the next item.
module diagonal_zigzag_reorder import dzr_pkg::*; #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PAddrW-1:0]        paddr,
  input  logic [PDataW-1:0]        pwdata,
  output logic [PDataW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ValueW-1:0] element_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueW-1:0] out_value_o,
  output logic [IdxW-1:0]          out_row_o,
  output logic [IdxW-1:0]          out_col_o,
  output logic                     out_last_o
);

  mem_wr_t               wr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  job_push, job_pop, job_valid, walk_busy, hold;
  job_t                  job_in, job_out;

  // the store is shared, so loading waits until the walk has read it all
  assign hold = job_valid || walk_busy;

  dzr_front #(
    .MAX_DIM   (MAX_DIM),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .element_value_i(element_value_i),
    .hold_i         (hold),
    .wr_o           (wr),
    .wr_data_o      (wr_data),
    .job_push_o     (job_push),
    .job_o          (job_in)
  );

  dzr_job_fifo u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .job_o  (job_out)
  );

  dzr_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .wr_data_i  (wr_data),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .busy_o     (walk_busy),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_value_o(out_value_o),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .out_last_o (out_last_o)
  );

endmodule
